// ===== rtl/aesbe_pkg.sv =====
// aesbe_pkg: shared types, constants and byte functions of the aes block encryption core
// depends on nothing; used by every module under rtl
package aesbe_pkg;

  localparam int unsigned NUM_ROUNDS_MAX = 14;
  localparam int unsigned WORD_CNT_W     = 6;

  // register indexes of the configuration port
  localparam logic [2:0] REG_KEY_MODE = 3'd0;
  localparam logic [2:0] REG_KEY_P0   = 3'd1;
  localparam logic [2:0] REG_KEY_P1   = 3'd2;
  localparam logic [2:0] REG_KEY_P2   = 3'd3;
  localparam logic [2:0] REG_KEY_P3   = 3'd4;

  // key length codes
  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  typedef enum logic {
    KS_IDLE,
    KS_EXPAND
  } ks_state_t;

  // per-stage round control
  typedef struct packed {
    logic pass_thru;   // round beyond the key's round count
    logic last_rnd;    // final round, no column mixing
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    d0 = gf_dbl(a0); d1 = gf_dbl(a1); d2 = gf_dbl(a2); d3 = gf_dbl(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

endpackage

// ===== rtl/aesbe_keyexp.sv =====
// aesbe_keyexp: key schedule expansion, one word a cycle, into the round key registers
// depends on aesbe_pkg
module aesbe_keyexp import aesbe_pkg::*; #(
  parameter int unsigned MAX_WORDS = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        restart,
  input  logic [1:0]  key_mode,
  input  logic [63:0] key_part [4],
  output logic        sched_valid,
  output logic [31:0] rk [MAX_WORDS]
);

  localparam int unsigned IDX_W = $clog2(MAX_WORDS);

  ks_state_t             state_r, state_nxt;
  logic                  valid_r, valid_nxt;
  logic [WORD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]            mod_r, mod_nxt;
  logic [7:0]            rc_r, rc_nxt;
  logic [31:0]           win_r [8];
  logic [31:0]           rk_r [MAX_WORDS];
  logic [3:0]            nk;
  logic [WORD_CNT_W-1:0] total;
  logic [31:0]           new_w, t, back_w;
  logic [63:0]           part;

  always_comb begin
    unique case (key_mode)
      MODE_128: nk = 4'd4;
      MODE_192: nk = 4'd6;
      default:  nk = 4'd8;
    endcase
    total = WORD_CNT_W'({nk, 2'b00} + 6'd28);
    part = key_part[cnt_r[2:1]];
    unique case (nk)
      4'd4:    back_w = win_r[3];
      4'd6:    back_w = win_r[5];
      default: back_w = win_r[7];
    endcase
    t = win_r[0];
    if (mod_r == 4'd0) begin
      t = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rc_r, 24'd0};
    end else if (nk == 4'd8 && mod_r == 4'd4) begin
      t = sub_word(win_r[0]);
    end
    if (cnt_r < WORD_CNT_W'(nk)) begin
      new_w = cnt_r[0] ? part[31:0] : part[63:32];
    end else begin
      new_w = back_w ^ t;
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    mod_nxt   = mod_r;
    rc_nxt    = rc_r;
    unique case (state_r)
      KS_IDLE: begin
        if (!valid_r && !restart) begin
          state_nxt = KS_EXPAND;
          cnt_nxt   = '0;
          mod_nxt   = '0;
          rc_nxt    = 8'h01;
        end
      end
      KS_EXPAND: begin
        cnt_nxt = cnt_r + 1'b1;
        mod_nxt = (mod_r == nk - 4'd1) ? 4'd0 : mod_r + 4'd1;
        if (cnt_r >= WORD_CNT_W'(nk) && mod_r == 4'd0) begin
          rc_nxt = gf_dbl(rc_r);
        end
        if (cnt_r == total - 1'b1) begin
          state_nxt = KS_IDLE;
          valid_nxt = 1'b1;
        end
      end
      default: state_nxt = KS_IDLE;
    endcase
    if (restart) begin
      state_nxt = KS_IDLE;
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_IDLE;
      valid_r <= 1'b0;
      cnt_r   <= '0;
      mod_r   <= '0;
      rc_r    <= 8'h01;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      mod_r   <= mod_nxt;
      rc_r    <= rc_nxt;
    end
  end

  // sliding window of the last eight words, newest at the front
  // words past the end of the store are dropped and read back as zero
  always_ff @(posedge clk) begin
    if (state_r == KS_EXPAND) begin
      win_r[0] <= (32'(cnt_r) < MAX_WORDS) ? new_w : '0;
      for (int j = 1; j < 8; j++) begin
        win_r[j] <= win_r[j-1];
      end
      if (32'(cnt_r) < MAX_WORDS) begin
        rk_r[cnt_r[IDX_W-1:0]] <= new_w;
      end
    end
  end

  assign sched_valid = valid_r;
  assign rk          = rk_r;

endmodule

// ===== rtl/aesbe_round.sv =====
// aesbe_round: one registered cipher round (sub bytes, shift rows, mix columns, key add)
// depends on aesbe_pkg; last round skips mix columns, pass_thru bypasses the round
module aesbe_round import aesbe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [127:0] in_state,
  input  logic [127:0] rkey,
  input  round_ctl_t   ctl,
  output logic         out_vld,
  output logic [127:0] out_state
);

  logic         vld_r;
  logic [127:0] state_r, state_nxt, sub_s, shf_s;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sub_s[127-32*c -: 32] = sub_word(in_state[127-32*c -: 32]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf_s[127-32*c-8*r -: 8] = sub_s[127-32*((c+r)%4)-8*r -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      state_nxt[127-32*c -: 32] = (ctl.last_rnd ? shf_s[127-32*c -: 32]
                                                : mix_col(shf_s[127-32*c -: 32]))
                                  ^ rkey[127-32*c -: 32];
    end
    if (ctl.pass_thru) begin
      state_nxt = in_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign out_vld   = vld_r;
  assign out_state = state_r;

endmodule

// ===== rtl/aes_block_encrypt_core.sv =====
// aes_block_encrypt_core: top level of the forward aes block cipher, 128/192/256-bit keys
// depends on aesbe_pkg, aesbe_keyexp and aesbe_round
//
// One plaintext block enters on each start with busy low and its ciphertext leaves the
// last round stage, marked by out_valid for exactly one cycle; the pipeline takes a new item
// every cycle while busy is low and the receiver cannot stall it. The pipeline is one key-add
// stage plus fourteen round stages; shorter keys pass the unused rounds straight through. After
// reset and after every write to a key register, busy stays high while the key schedule is
// expanded one word a cycle (44, 52 or 60 words for 128, 192 or 256-bit keys).
// Write configuration only with no item in flight.
module aes_block_encrypt_core import aesbe_pkg::*; #(
  parameter int unsigned MAX_SCHEDULE_WORDS = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port, registers at 8-byte steps
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // item input
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_plaintext_high,
  input  logic [63:0] in_plaintext_low,
  // item output
  output logic        out_valid,
  output logic [63:0] out_ciphertext_high,
  output logic [63:0] out_ciphertext_low
);

  logic [1:0]   key_mode_r;
  logic [63:0]  key_part_r [4];
  logic         cfg_wr, cfg_hit;
  logic [2:0]   cfg_idx;
  logic         sched_valid;
  logic [31:0]  rk [MAX_SCHEDULE_WORDS];
  logic [127:0] rkey [NUM_ROUNDS_MAX+1];
  logic [3:0]   num_rnd;
  logic         vld [NUM_ROUNDS_MAX+1];
  logic [127:0] st [NUM_ROUNDS_MAX+1];
  logic         vld0_r;
  logic [127:0] st0_r;
  round_ctl_t   ctl [NUM_ROUNDS_MAX+1];

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (cfg_idx <= REG_KEY_P3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= MODE_128;
      for (int k = 0; k < 4; k++) begin
        key_part_r[k] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEY_MODE: key_mode_r    <= pwdata[1:0];
        REG_KEY_P0:   key_part_r[0] <= pwdata;
        REG_KEY_P1:   key_part_r[1] <= pwdata;
        REG_KEY_P2:   key_part_r[2] <= pwdata;
        REG_KEY_P3:   key_part_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KEY_MODE: prdata = {62'd0, key_mode_r};
      REG_KEY_P0:   prdata = key_part_r[0];
      REG_KEY_P1:   prdata = key_part_r[1];
      REG_KEY_P2:   prdata = key_part_r[2];
      REG_KEY_P3:   prdata = key_part_r[3];
      default:      prdata = '0;
    endcase
  end

  // key schedule; any key register write forces a fresh expansion
  aesbe_keyexp #(.MAX_WORDS(MAX_SCHEDULE_WORDS)) u_keyexp (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_hit),
    .key_mode    (key_mode_r),
    .key_part    (key_part_r),
    .sched_valid (sched_valid),
    .rk          (rk)
  );

  assign busy = !sched_valid;

  // round keys per stage; words past a short store read as zero
  for (genvar k = 0; k <= NUM_ROUNDS_MAX; k++) begin : g_rkey
    for (genvar c = 0; c < 4; c++) begin : g_word
      if (4*k + c < MAX_SCHEDULE_WORDS) begin : g_in
        assign rkey[k][127-32*c -: 32] = rk[4*k+c];
      end else begin : g_out
        assign rkey[k][127-32*c -: 32] = '0;
      end
    end
  end

  always_comb begin
    unique case (key_mode_r)
      MODE_128: num_rnd = 4'd10;
      MODE_192: num_rnd = 4'd12;
      default:  num_rnd = 4'd14;
    endcase
  end

  // initial key add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    st0_r <= {in_plaintext_high, in_plaintext_low} ^ rkey[0];
  end

  assign vld[0] = vld0_r;
  assign st[0]  = st0_r;
  assign ctl[0] = '0;

  // round stages, one per register
  for (genvar k = 1; k <= NUM_ROUNDS_MAX; k++) begin : g_rnd
    assign ctl[k].pass_thru = 4'(k) > num_rnd;
    assign ctl[k].last_rnd  = 4'(k) == num_rnd;

    aesbe_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld[k-1]),
      .in_state  (st[k-1]),
      .rkey      (rkey[k]),
      .ctl       (ctl[k]),
      .out_vld   (vld[k]),
      .out_state (st[k])
    );
  end

  assign out_valid           = vld[NUM_ROUNDS_MAX];
  assign out_ciphertext_high = st[NUM_ROUNDS_MAX][127:64];
  assign out_ciphertext_low  = st[NUM_ROUNDS_MAX][63:0];

endmodule

// ===== tb/aes_block_encrypt_core_tb.sv =====
// aes_block_encrypt_core_tb: self-checking testbench of the forward aes block cipher core
// depends on aesbe_pkg (sbox table, register indexes) and the rtl under rtl/
`timescale 1ns / 100ps

module aes_block_encrypt_core_tb;
  import aesbe_pkg::*;

  localparam int unsigned LATENCY    = 15;
  localparam int unsigned DRAIN_WAIT = LATENCY + 5;
  // covers a full key expansion, plus a full sender gap and the pipeline
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned NUM_RANDOM  = 1500;
  // addresses past the last key register, writes there must be ignored
  localparam logic [2:0] REG_UNUSED_A = 3'd5;
  localparam logic [2:0] REG_UNUSED_C = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_plaintext_high = '0, in_plaintext_low = '0;
  logic        out_valid;
  logic [63:0] out_ciphertext_high, out_ciphertext_low;

  aes_block_encrypt_core u_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_plaintext_high, .in_plaintext_low,
    .out_valid, .out_ciphertext_high, .out_ciphertext_low
  );

  always #5 clk = ~clk;

  // predictor state: configuration as written and the expanded round keys
  logic [1:0]  key_mode;
  logic [63:0] key_bits [4];
  logic [31:0] round_keys [60];
  logic [127:0] cipher_q [$];
  int unsigned errors = 0;
  bit idle_on = 1'b1;

  function automatic logic [7:0] gf_x2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic int unsigned key_words();
    return (key_mode == MODE_128) ? 4 : (key_mode == MODE_192) ? 6 : 8;
  endfunction

  // rebuild the round key words from the current key length and key bits
  function automatic void build_round_keys();
    int unsigned nk, total;
    logic [31:0] t;
    logic [7:0]  rc;
    nk = key_words();
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int unsigned i = 0; i < nk; i++)
      round_keys[i] = i[0] ? key_bits[i >> 1][31:0] : key_bits[i >> 1][63:32];
    for (int unsigned i = nk; i < total; i++) begin
      t = round_keys[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_x2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      round_keys[i] = round_keys[i - nk] ^ t;
    end
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
    logic [31:0] s [4];
    logic [31:0] t [4];
    logic [7:0]  a [4];
    logic [7:0]  d [4];
    int unsigned nr;
    nr = key_words() + 6;
    for (int c = 0; c < 4; c++) s[c] = pt[127 - 32*c -: 32] ^ round_keys[c];
    for (int unsigned rnd = 1; rnd <= nr; rnd++) begin
      for (int c = 0; c < 4; c++) s[c] = sbox_word(s[c]);
      // row r of column c comes from column c + r
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[c][31 - 8*r -: 8] = s[(c + r) % 4][31 - 8*r -: 8];
      for (int c = 0; c < 4; c++) begin
        if (rnd < nr) begin
          for (int r = 0; r < 4; r++) begin
            a[r] = t[c][31 - 8*r -: 8];
            d[r] = gf_x2(a[r]);
          end
          t[c] = {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3], a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3],
                  a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3], d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3]};
        end
        s[c] = t[c] ^ round_keys[4*rnd + c];
      end
    end
    return {s[0], s[1], s[2], s[3]};
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one plaintext item, with an optional random gap in front of it
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    if (idle_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(17, 1)) @(negedge clk);
    end
    start <= 1'b1;
    in_plaintext_high <= hi;
    in_plaintext_low <= lo;
    // busy read at the edge itself is the value that edge sees
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    cipher_q = {cipher_q, encrypt_block({hi, lo})};
  endtask

  // hold off until the pipeline is empty and any trailing work has settled
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    wait (cipher_q.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_MODE: key_mode = val[1:0];
      REG_KEY_P0:   key_bits[0] = val;
      REG_KEY_P1:   key_bits[1] = val;
      REG_KEY_P2:   key_bits[2] = val;
      REG_KEY_P3:   key_bits[3] = val;
      default: ;
    endcase
    build_round_keys();
  endtask

  task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    drain();
    reg_write(REG_KEY_MODE, {$urandom, 30'h0, mode});
    reg_write(REG_KEY_P0, k0);
    reg_write(REG_KEY_P1, k1);
    reg_write(REG_KEY_P2, k2);
    reg_write(REG_KEY_P3, k3);
  endtask

  // reset key of all zeros, then extreme keys and plaintexts at every key length
  task automatic test_extremes();
    send_block('0, '0);
    send_block('1, '1);
    for (int m = 0; m < 4; m++) begin
      load_key(m[1:0], '1, '1, '1, '1);
      send_block('0, '1);
      send_block('1, '0);
      load_key(m[1:0], '0, '0, '0, '0);
      send_block('1, '1);
    end
  endtask

  // known-answer style keys, byte ramp; mode code 3 must act as the 256-bit length
  task automatic test_ramp_keys();
    for (int m = 0; m < 4; m++) begin
      load_key(m[1:0], 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    end
  endtask

  // writes past the last key register leave the schedule alone
  task automatic test_unused_regs();
    drain();
    for (logic [2:0] r = REG_UNUSED_A; r <= REG_UNUSED_C && r != 0; r++) reg_write(r, rand64());
    send_block(rand64(), rand64());
    send_block(rand64(), rand64());
  endtask

  // bulk traffic under random keys; gaps stop for the final stretch
  task automatic test_random();
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0)
        load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
      else if (n % 97 == 0)
        drain();
      idle_on = (n < NUM_RANDOM - 250);
      send_block({$urandom, $urandom}, {$urandom, $urandom});
    end
    start <= 1'b0;
  endtask

  // result checker, one ciphertext per out_valid cycle
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_valid) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected ciphertext %h %h", out_ciphertext_high, out_ciphertext_low);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (out_ciphertext_high !== want[127:64]) begin
          $error("ciphertext_high expected %h actual %h", want[127:64], out_ciphertext_high);
          errors++;
        end
        if (out_ciphertext_low !== want[63:0]) begin
          $error("ciphertext_low expected %h actual %h", want[63:0], out_ciphertext_low);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item accepted in either direction and no register access
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    key_mode = MODE_128;
    for (int i = 0; i < 4; i++) key_bits[i] = '0;
    build_round_keys();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_ramp_keys();
    test_unused_regs();
    test_random();
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
